// ===== design/tsbu_pkg.sv =====
// Package for the tree-selected block upscaler: types, constants, feature permutation.
// No dependencies.
`default_nettype none
package tsbu_pkg;
  typedef enum logic [2:0] {
    CMD_ROW   = 3'd0,
    CMD_PROJ  = 3'd1,
    CMD_LINK  = 3'd2,
    CMD_LOW   = 3'd3,
    CMD_HIGH  = 3'd4,
    CMD_MODEL = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  row_index;
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [7:0]  pixel_c;
    logic [7:0]  pixel_d;
    logic [13:0] table_addr;
    logic [27:0] table_data;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FEAT, ST_WALK_RD, ST_WALK, ST_DOT, ST_DONE
  } state_t;

  localparam int PROJ_ENTRIES = 240;
  localparam int TREE_NODES   = 256;
  localparam int MODEL_COUNT  = 256;

  // selector s (1..15) -> zero-based feature index
  function automatic logic [3:0] perm_f(input logic [3:0] s);
    logic [3:0] r;
    unique case (s)
      4'd1:  r = 4'd1;
      4'd2:  r = 4'd7;
      4'd3:  r = 4'd2;
      4'd4:  r = 4'd11;
      4'd5:  r = 4'd9;
      4'd6:  r = 4'd0;
      4'd7:  r = 4'd3;
      4'd8:  r = 4'd10;
      4'd9:  r = 4'd13;
      4'd10: r = 4'd5;
      4'd11: r = 4'd8;
      4'd12: r = 4'd14;
      4'd13: r = 4'd6;
      4'd14: r = 4'd12;
      4'd15: r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/tsbu_fifo.sv =====
// Short request queue between the front (input accept) and the back (engine).
// Depends on tsbu_pkg.
`default_nettype none
module tsbu_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire tsbu_pkg::req_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output tsbu_pkg::req_t     rd_data,
  output logic               empty
);
  import tsbu_pkg::*;
  req_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ===== design/tsbu_engine.sv =====
// Back end: table storage, feature projection, tree walk, model dot products.
// Depends on tsbu_pkg.
`default_nettype none
module tsbu_engine #(
  parameter int FEATURE_COUNT = 15
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [8:0]     step_limit,
  input  wire logic           req_valid,
  input  wire tsbu_pkg::req_t req,
  output logic                req_take,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic signed [15:0]  res_hr [4],
  output logic [7:0]          res_model,
  output logic                res_err
);
  import tsbu_pkg::*;
  localparam int NW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam int MW = (MODEL_COUNT > 1) ? $clog2(MODEL_COUNT) : 1;
  localparam int CW = MW + 6;
  localparam int MODEL_ENTRIES = MODEL_COUNT * 64;

  logic [7:0]         pix_r [16];
  logic signed [7:0]  proj_mem [PROJ_ENTRIES];
  logic [27:0]        link_mem [TREE_NODES];
  logic signed [23:0] low_mem [TREE_NODES];
  logic signed [23:0] high_mem [TREE_NODES];
  logic signed [15:0] coef_mem [MODEL_ENTRIES];

  logic signed [19:0] feat_r [15];
  state_t             st_r, st_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [8:0]         steps_r, steps_nxt;
  logic [NW-1:0]      node_r, node_nxt;
  logic [MW-1:0]      model_r, model_nxt;
  logic               err_r, err_nxt;
  logic signed [19:0] facc_r;
  logic signed [31:0] dacc_r;

  logic signed [7:0]  proj_q_r;
  logic [27:0]        link_q_r;
  logic signed [23:0] low_q_r, high_q_r;
  logic signed [15:0] coef_q_r;
  logic [7:0]         pix_q_r;
  logic [7:0]         proj_ra;
  logic [CW-1:0]      coef_ra;
  logic [3:0]         rd_p, rd_p_r;

  wire is_row3 = req_valid && req.cmd == CMD_ROW && req.row_index == 2'd3;

  // table writes and pixel rows
  always_ff @(posedge clk) begin
    if (req_take) begin
      unique case (req.cmd)
        CMD_ROW: begin
          pix_r[{2'd0, req.row_index}]  <= req.pixel_a;
          pix_r[{2'd1, req.row_index}]  <= req.pixel_b;
          pix_r[{2'd2, req.row_index}]  <= req.pixel_c;
          pix_r[{2'd3, req.row_index}]  <= req.pixel_d;
        end
        CMD_PROJ:
          if (req.table_addr < 14'(PROJ_ENTRIES)) proj_mem[req.table_addr[7:0]] <= req.table_data[7:0];
        CMD_LINK:
          if (32'(req.table_addr) < TREE_NODES) link_mem[req.table_addr[NW-1:0]] <= req.table_data;
        CMD_LOW:
          if (32'(req.table_addr) < TREE_NODES) low_mem[req.table_addr[NW-1:0]] <= req.table_data[23:0];
        CMD_HIGH:
          if (32'(req.table_addr) < TREE_NODES) high_mem[req.table_addr[NW-1:0]] <= req.table_data[23:0];
        CMD_MODEL:
          if (32'(req.table_addr) < MODEL_ENTRIES) coef_mem[req.table_addr[CW-1:0]] <= req.table_data[15:0];
        default: ;
      endcase
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    proj_q_r <= proj_mem[proj_ra];
    coef_q_r <= coef_mem[coef_ra];
    link_q_r <= link_mem[node_nxt];
    low_q_r  <= low_mem[node_nxt];
    high_q_r <= high_mem[node_nxt];
    pix_q_r  <= pix_r[rd_p];
    rd_p_r   <= rd_p;
  end

  // FEAT: cnt = f*16+p issue, registered reads; runs 0..240
  // DOT: cnt = k*16+p issue, 0..63
  wire [3:0] fsel   = link_q_r[3:0];
  wire [3:0] fidx   = perm_f(fsel);
  wire signed [19:0] fval = (32'(fidx) < FEATURE_COUNT) ? feat_r[fidx] : 20'sd0;
  logic [7:0] fc_r;

  always_comb begin
    proj_ra = fc_r;
    rd_p    = fc_r[3:0];
    coef_ra = {model_r, cnt_r};
    if (st_r == ST_DOT) rd_p = cnt_r[3:0];
  end

  logic signed [16:0] pprod;
  logic signed [24:0] dprod;
  logic               fvalid_r, dvalid_r;
  logic [1:0]         dk_r;
  logic               dlast_r;
  logic [8:0]         fcnt_n;

  assign pprod = $signed({1'b0, pix_q_r}) * proj_q_r;
  assign dprod = $signed({1'b0, pix_q_r}) * coef_q_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; steps_nxt = steps_r; node_nxt = node_r;
    model_nxt = model_r; err_nxt = err_r;
    req_take = 1'b0;
    fcnt_n = {1'b0, fc_r};
    unique case (st_r)
      ST_IDLE: begin
        node_nxt = '0;
        // a new block waits until the previous result has been popped
        if (req_valid && (!is_row3 || !res_valid || res_ready)) begin
          req_take = 1'b1;
          if (is_row3) begin
            st_nxt = ST_FEAT; fcnt_n = '0;
          end
        end
      end
      ST_FEAT: begin
        if (fc_r != 8'd240) fcnt_n = {1'b0, fc_r} + 9'd1;
        else st_nxt = ST_WALK_RD;
        steps_nxt = '0; err_nxt = 1'b0; model_nxt = '0;
      end
      ST_WALK_RD: st_nxt = ST_WALK;
      ST_WALK: begin
        if (steps_r >= step_limit) begin
          err_nxt = 1'b1; st_nxt = ST_DONE;
        end else begin
          steps_nxt = steps_r + 9'd1;
          if (fsel == 4'd0) begin
            model_nxt = MW'(link_q_r[11:4] % 9'(MODEL_COUNT));
            st_nxt = ST_DOT; cnt_nxt = '0;
          end else begin
            if (fval < low_q_r)       node_nxt = NW'(link_q_r[11:4] % 9'(TREE_NODES));
            else if (fval > high_q_r) node_nxt = NW'(link_q_r[27:20] % 9'(TREE_NODES));
            else                      node_nxt = NW'(link_q_r[19:12] % 9'(TREE_NODES));
            st_nxt = ST_WALK_RD;
          end
        end
      end
      ST_DOT: begin
        if (dlast_r) st_nxt = ST_DONE;
        if (cnt_r != 6'd63) cnt_nxt = cnt_r + 6'd1;
      end
      ST_DONE: if (!res_valid || res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fc_r <= '0; res_valid <= 1'b0; fvalid_r <= 1'b0; dvalid_r <= 1'b0;
      dlast_r <= 1'b0; cnt_r <= '0; steps_r <= '0; node_r <= '0; model_r <= '0;
      err_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; steps_r <= steps_nxt; node_r <= node_nxt;
      model_r <= model_nxt; err_r <= err_nxt;
      fc_r <= fcnt_n[7:0];
      fvalid_r <= (st_r == ST_FEAT) && (fc_r != 8'd240);
      dvalid_r <= (st_r == ST_DOT) && !dlast_r;
      dlast_r  <= (st_r == ST_DOT) && (cnt_r == 6'd63) && !dlast_r;
      dk_r <= cnt_r[5:4];
      if (st_r == ST_DONE && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end

  // feature and dot accumulation on registered reads
  logic [7:0] fprev_r;
  always_ff @(posedge clk) begin
    fprev_r <= fc_r;
    if (fvalid_r) begin
      if (fprev_r[3:0] == 4'd0) facc_r <= 20'(pprod);
      else facc_r <= facc_r + 20'(pprod);
      if (fprev_r[3:0] == 4'd15) feat_r[fprev_r[7:4]] <= facc_r + 20'(pprod);
    end
    if (dvalid_r) begin
      if (rd_p_r == 4'd0) dacc_r <= 32'(dprod);
      else dacc_r <= dacc_r + 32'(dprod);
    end
  end

  // final sum of each output is registered and closes in the cycle after its last product
  logic        dclose_r;
  logic [1:0]  dclose_k_r;
  logic signed [31:0] dsum_r;
  logic signed [15:0] res_hr_acc [4];
  always_ff @(posedge clk) begin
    dclose_r   <= dvalid_r && rd_p_r == 4'd15;
    dclose_k_r <= dk_r;
    dsum_r     <= dacc_r + 32'(dprod);
  end
  wire signed [32:0] rsum = (33'(dsum_r) + 33'sd2048) >>> 12;
  always_ff @(posedge clk) begin
    if (dclose_r) begin
      if (rsum > 33'sd32767)       res_hr_acc[dclose_k_r] <= 16'sh7FFF;
      else if (rsum < -33'sd32768) res_hr_acc[dclose_k_r] <= 16'sh8000;
      else                         res_hr_acc[dclose_k_r] <= rsum[15:0];
    end
  end

  assign res_hr[0] = err_r ? 16'sd0 : res_hr_acc[0];
  assign res_hr[1] = err_r ? 16'sd0 : res_hr_acc[1];
  assign res_hr[2] = err_r ? 16'sd0 : res_hr_acc[2];
  assign res_hr[3] = err_r ? 16'sd0 : res_hr_acc[3];
  assign res_model = err_r ? 8'd0 : 8'(model_r);
  assign res_err   = err_r;
endmodule
`default_nettype wire

// ===== design/tree_selected_block_upscaler.sv =====
// Tree-selected 4x4 block upscaler top level: input queue, engine, config register.
// Depends on tsbu_pkg, tsbu_fifo, tsbu_engine.
// Table writes and rows 0..2: one per cycle while the engine is idle, applied when taken.
// Row 3: feature projection, then a tree walk with a read and a compare per node, then
// the model dot products; a walk that hits the step limit ends with the error flag set.
// Next row 3 waits until the previous result is popped. Sync active-low reset; limit 256.
`default_nettype none
module tree_selected_block_upscaler #(
  parameter int FEATURE_COUNT = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_walk_step_limit,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [1:0]         in_row_index,
  input  wire logic [7:0]         in_pixel_a,
  input  wire logic [7:0]         in_pixel_b,
  input  wire logic [7:0]         in_pixel_c,
  input  wire logic [7:0]         in_pixel_d,
  input  wire logic [13:0]        in_table_addr,
  input  wire logic [27:0]        in_table_data,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_hr_top_left,
  output logic signed [15:0]      out_hr_bottom_left,
  output logic signed [15:0]      out_hr_top_right,
  output logic signed [15:0]      out_hr_bottom_right,
  output logic [7:0]              out_model_used,
  output logic                    out_walk_error
);
  import tsbu_pkg::*;
  logic [8:0] limit_r;
  req_t       wr_req, q_req;
  logic       q_empty, take, res_valid;
  logic signed [15:0] hr [4];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 9'd256;
    else if (cfg_valid) limit_r <= cfg_walk_step_limit;
  end

  assign wr_req = '{cmd: cmd_t'(in_cmd), row_index: in_row_index, pixel_a: in_pixel_a,
                    pixel_b: in_pixel_b, pixel_c: in_pixel_c, pixel_d: in_pixel_d,
                    table_addr: in_table_addr, table_data: in_table_data};

  tsbu_fifo u_fifo (
    .clk, .rst_n, .wr_en(push && !full), .wr_data(wr_req), .full,
    .rd_en(take), .rd_data(q_req), .empty(q_empty)
  );

  tsbu_engine #(.FEATURE_COUNT(FEATURE_COUNT)) u_eng (
    .clk, .rst_n, .step_limit(limit_r), .req_valid(!q_empty), .req(q_req),
    .req_take(take), .res_valid, .res_ready(pop), .res_hr(hr),
    .res_model(out_model_used), .res_err(out_walk_error)
  );

  assign empty               = !res_valid;
  assign out_hr_top_left     = hr[0];
  assign out_hr_bottom_left  = hr[1];
  assign out_hr_top_right    = hr[2];
  assign out_hr_bottom_right = hr[3];
endmodule
`default_nettype wire
